// ===== hdl/pcsa_cardinality_sketch_macros.svh =====
// ---------------------------------------------------------------------------
// PCSA sketch assertion macros
// Concurrent assertion wrappers shared by the sketch modules.
// ---------------------------------------------------------------------------
`ifndef PCSA_CARDINALITY_SKETCH_MACROS_SVH
`define PCSA_CARDINALITY_SKETCH_MACROS_SVH

// same-cycle implication
`define PCSA_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PCSA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/pcsa_pkg.sv =====
// ---------------------------------------------------------------------------
// PCSA sketch package
// Item types, state encodings, fixed-point constants and the root table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcsa_pkg;

  localparam int NUM_BUCKETS_DEF  = 256;
  localparam int BUCKET_SHIFT_DEF = 56;

  localparam int HASH_W     = 64;
  localparam int EST_W      = 64;
  localparam int RANK_SUM_W = 15;
  localparam int INV_PHI_W  = 18;
  localparam int FRAC_W     = 8;
  localparam int ACC_W      = 18;
  localparam int ROOT_W     = 17;
  localparam int RANK_W     = 7;

  localparam logic [INV_PHI_W-1:0] INV_PHI_RESET = 18'd84725;
  localparam logic [ACC_W-1:0]     POW_ONE       = 18'd65536;
  localparam logic [ACC_W-1:0]     ACC_LIMIT     = 18'd131072;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_QUERY  = 1'b1;

  // Q16 values of 2^(2^j/256), j = 0..7
  localparam logic [ROOT_W-1:0] ROOT_Q16 [8] = '{
    17'd65714, 17'd65892, 17'd66250, 17'd66971,
    17'd68438, 17'd71468, 17'd77936, 17'd92682
  };

  typedef struct packed {
    logic              req_type;
    logic [HASH_W-1:0] hash_value;
  } in_item_t;

  typedef struct packed {
    logic [EST_W-1:0]      estimate;
    logic [RANK_SUM_W-1:0] rank_sum;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_INS_MUL,
    S_INS_RD,
    S_INS_WR,
    S_Q_WALK,
    S_Q_DRAIN,
    S_Q_EST,
    S_RESP
  } top_state_t;

  typedef enum logic [2:0] {
    E_IDLE,
    E_DIV,
    E_POW,
    E_PHI,
    E_SCALE,
    E_SHIFT
  } est_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } est_status_t;

endpackage

// ===== hdl/pcsa_cardinality_sketch.sv =====
// Insert: the item walks S_INS_MUL, S_INS_RD and S_INS_WR; S_RESP then loads the result register.
// Query: a bitmap walk over all NUM_BUCKETS buckets, a drain, a reciprocal divide,
// 8 power steps, scaling in E_PHI, E_SCALE and E_SHIFT, and a response state.
// One item at a time; an unread result holds the input off.
// Reset: synchronous; a clearing pass over all NUM_BUCKETS buckets zeroes the bitmaps,
// in_ready stays low meanwhile, configuration writes are taken throughout.
// ---------------------------------------------------------------------------
// PCSA cardinality sketch
// Bitmap memory with read-modify-write inserts and a walking query that
// feeds the serial estimator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pcsa_cardinality_sketch_macros.svh"

module pcsa_cardinality_sketch import pcsa_pkg::*; #(
  parameter int NUM_BUCKETS  = NUM_BUCKETS_DEF,
  parameter int BUCKET_SHIFT = BUCKET_SHIFT_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_wr_en,
  input  logic [INV_PHI_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(NUM_BUCKETS);
  localparam int SUM_W = $clog2(64 * NUM_BUCKETS + 1);
  localparam int X_W   = HASH_W - BUCKET_SHIFT;

  top_state_t state_r, state_nxt;

  logic [HASH_W-1:0]    mem [NUM_BUCKETS];
  logic [HASH_W-1:0]    rd_data_r;
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_wa;
  logic [HASH_W-1:0]    mem_wd;
  logic [IDX_W-1:0]     mem_ra;

  logic [HASH_W-1:0]    hash_r;
  logic [IDX_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     idx;
  logic                 rd_vld_r;
  logic                 rank_vld_r;
  logic [RANK_W-1:0]    rank_r;
  logic [SUM_W-1:0]     sum_r;
  logic [INV_PHI_W-1:0] inv_phi_r;
  out_item_t            res_r;
  out_item_t            out_data_r;
  logic                 out_valid_r;
  logic                 out_load;
  logic                 est_start;
  est_status_t          est_status;
  logic [EST_W-1:0]     est_value;
  logic [HASH_W-1:0]    low_zero_bit;

  function automatic logic [RANK_W-1:0] low_zero_rank(input logic [HASH_W-1:0] d);
    logic [HASH_W-1:0] z;
    logic [RANK_W-1:0] r;
    z = ~d & (d + 64'd1);
    r = '0;
    for (int i = 0; i < HASH_W; i++) begin
      if (z[i]) r = r | RANK_W'(i);
    end
    if (z == '0) r = RANK_W'(HASH_W);
    return r;
  endfunction

  pcsa_bucket_index #(
    .NUM_BUCKETS(NUM_BUCKETS),
    .X_W        (X_W)
  ) u_index (
    .clk(clk),
    .x  (hash_r[HASH_W-1:BUCKET_SHIFT]),
    .idx(idx)
  );

  pcsa_estimator #(
    .NUM_BUCKETS(NUM_BUCKETS)
  ) u_est (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (est_start),
    .sum_in  (sum_r),
    .inv_phi (inv_phi_r),
    .status  (est_status),
    .estimate(est_value)
  );

  assign low_zero_bit = ~hash_r & (hash_r + 64'd1);
  assign out_load     = (state_r == S_RESP) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (cnt_r == IDX_W'(NUM_BUCKETS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.req_type == REQ_QUERY) ? S_Q_WALK : S_INS_MUL;
        end
      end
      S_INS_MUL: state_nxt = S_INS_RD;
      S_INS_RD:  state_nxt = S_INS_WR;
      S_INS_WR:  state_nxt = S_RESP;
      S_Q_WALK: begin
        if (cnt_r == IDX_W'(NUM_BUCKETS - 1)) state_nxt = S_Q_DRAIN;
      end
      S_Q_DRAIN: begin
        if (est_start) state_nxt = S_Q_EST;
      end
      S_Q_EST: begin
        if (est_status.done) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state_r == S_IDLE);
    mem_we    = 1'b0;
    mem_wa    = cnt_r;
    mem_wd    = '0;
    mem_ra    = cnt_r;
    est_start = 1'b0;
    case (state_r)
      S_CLEAR: mem_we = 1'b1;
      S_INS_RD: mem_ra = idx;
      S_INS_WR: begin
        mem_we = 1'b1;
        mem_wa = idx_r;
        mem_wd = rd_data_r | low_zero_bit;
      end
      S_Q_DRAIN: est_start = !rd_vld_r && !rank_vld_r && !est_status.busy;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      rd_vld_r    <= 1'b0;
      rank_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
      inv_phi_r   <= INV_PHI_RESET;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= (state_r == S_Q_WALK);
      rank_vld_r <= rd_vld_r;
      if (state_r == S_CLEAR || state_r == S_Q_WALK) begin
        cnt_r <= (cnt_r == IDX_W'(NUM_BUCKETS - 1)) ? '0 : cnt_r + IDX_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) inv_phi_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE) begin
      hash_r <= in_data.hash_value;
      sum_r  <= '0;
    end else if (rank_vld_r) begin
      sum_r <= sum_r + SUM_W'(rank_r);
    end
    if (state_r == S_INS_RD) idx_r <= idx;
    rank_r <= low_zero_rank(rd_data_r);
    if (state_r == S_INS_WR) res_r <= '0;
    if (state_r == S_Q_EST && est_status.done) begin
      res_r.estimate <= est_value;
      res_r.rank_sum <= RANK_SUM_W'(sum_r);
    end
    if (out_load) out_data_r <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `PCSA_ASSERT_NEXT(a_ins_write, clk, rst_n,
    in_valid && in_ready && (in_data.req_type == REQ_INSERT), ##2 mem_we,
    "insert did not write back")
  `PCSA_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r), $past(state_r) == S_RESP,
    "result register loaded outside response")
  `PCSA_ASSERT(a_sum_hold, clk, rst_n, state_r == S_Q_EST, $stable(sum_r),
    "rank sum moved during estimate")
  `PCSA_ASSERT(a_wa_range, clk, rst_n, mem_we, mem_wa <= IDX_W'(NUM_BUCKETS - 1),
    "bitmap write out of range")

endmodule

// ===== hdl/pcsa_bucket_index.sv =====
// ---------------------------------------------------------------------------
// PCSA bucket index
// Reduces the top hash bits modulo the bucket count: reciprocal multiply,
// registered, then back-multiply and one corrective subtract.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcsa_bucket_index import pcsa_pkg::*; #(
  parameter int  NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int  X_W         = HASH_W - BUCKET_SHIFT_DEF,
  localparam int IDX_W       = $clog2(NUM_BUCKETS)
) (
  input  logic             clk,
  input  logic [X_W-1:0]   x,
  output logic [IDX_W-1:0] idx
);

  localparam int RECIP_W = X_W + 1;
  localparam int PROD_W  = X_W + RECIP_W;
  localparam int NB_W    = $clog2(NUM_BUCKETS + 1);
  localparam int QN_W    = RECIP_W + NB_W;
  localparam int R_W     = (X_W > NB_W) ? X_W : NB_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((1 << X_W) / NUM_BUCKETS);

  logic [X_W-1:0]    x_r;
  logic [PROD_W-1:0] prod_r;
  logic [RECIP_W-1:0] q_est;
  logic [QN_W-1:0]   qn;
  logic [R_W-1:0]    r_est;
  logic [R_W-1:0]    r_fix;

  always_ff @(posedge clk) begin
    x_r    <= x;
    prod_r <= PROD_W'(x) * PROD_W'(RECIP);
  end

  // estimate is exact or one low
  assign q_est = prod_r[PROD_W-1:X_W];
  assign qn    = QN_W'(q_est) * QN_W'(NUM_BUCKETS);
  assign r_est = R_W'(x_r - qn[X_W-1:0]);
  assign r_fix = (r_est >= R_W'(NUM_BUCKETS)) ? (r_est - R_W'(NUM_BUCKETS)) : r_est;
  assign idx   = r_fix[IDX_W-1:0];

endmodule

// ===== hdl/pcsa_estimator.sv =====
// ---------------------------------------------------------------------------
// PCSA estimator
// Reciprocal-multiply division of the rank sum by the bucket count, serial
// fractional power of two, bias scaling and saturating final shift.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "pcsa_cardinality_sketch_macros.svh"

module pcsa_estimator import pcsa_pkg::*; #(
  parameter int  NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int SUM_W       = $clog2(64 * NUM_BUCKETS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SUM_W-1:0]     sum_in,
  input  logic [INV_PHI_W-1:0] inv_phi,
  output est_status_t          status,
  output logic [EST_W-1:0]     estimate
);

  localparam int DVD_W  = SUM_W + FRAC_W;
  localparam int NB_W   = $clog2(NUM_BUCKETS + 1);
  localparam int RSH    = DVD_W + NB_W;
  localparam int RCP_W  = DVD_W + 2;
  localparam int QP_W   = DVD_W + RCP_W;
  localparam int PROD_W = ACC_W + ROOT_W;
  localparam int P_W    = ACC_W + INV_PHI_W;
  localparam int MP_W   = P_W + NB_W;
  localparam logic [RCP_W-1:0] RCP =
    RCP_W'(((64'd1 << RSH) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS));

  est_state_t state_r, state_nxt;

  logic              done_r;
  logic [DVD_W-1:0]  dvd_r;
  logic [ACC_W-1:0]  acc_r;
  logic [2:0]        bit_r;
  logic [P_W-1:0]    p_r;
  logic [MP_W-1:0]   mp_r;
  logic [EST_W-1:0]  est_r;

  logic [QP_W-1:0]     quot_prod;
  logic [FRAC_W-1:0]   frac;
  logic [SUM_W-1:0]    quo;
  logic [PROD_W-1:0]   pow_prod;
  logic [ACC_W-1:0]    acc_step;
  logic [SUM_W-1:0]    up_shift;
  logic [5:0]          dn_shift;
  logic [63:0]         mp64;
  logic [127:0]        wide;
  logic [EST_W-1:0]    est_calc;

  // divide by the bucket count; the rounded-up reciprocal is exact over the dividend range
  assign quot_prod = QP_W'(dvd_r) * QP_W'(RCP);

  assign frac = dvd_r[FRAC_W-1:0];
  assign quo  = dvd_r[DVD_W-1:FRAC_W];

  // rounded Q16 multiply
  assign pow_prod = PROD_W'(acc_r) * PROD_W'(ROOT_Q16[bit_r]);
  assign acc_step = ACC_W'((pow_prod + PROD_W'(32768)) >> 16);

  // scale by 2^(q-32), saturate
  assign mp64     = 64'(mp_r);
  assign up_shift = quo - SUM_W'(32);
  assign dn_shift = 6'(6'd32 - {1'b0, quo[4:0]});
  assign wide     = {64'd0, mp64} << up_shift[5:0];

  always_comb begin
    if (mp_r == '0) begin
      est_calc = '0;
    end else if (quo < SUM_W'(32)) begin
      est_calc = mp64 >> dn_shift;
    end else if (up_shift >= SUM_W'(64)) begin
      est_calc = '1;
    end else if (wide[127:64] != 64'd0) begin
      est_calc = '1;
    end else begin
      est_calc = wide[63:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      E_IDLE: begin
        if (start) state_nxt = E_DIV;
      end
      E_DIV:   state_nxt = E_POW;
      E_POW: begin
        if (bit_r == 3'd0) state_nxt = E_PHI;
      end
      E_PHI:   state_nxt = E_SCALE;
      E_SCALE: state_nxt = E_SHIFT;
      E_SHIFT: state_nxt = E_IDLE;
      default: state_nxt = E_IDLE;
    endcase
  end

  always_comb begin
    status.busy = (state_r != E_IDLE);
    status.done = done_r;
    estimate    = est_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == E_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      E_IDLE: begin
        dvd_r <= {sum_in, {FRAC_W{1'b0}}};
      end
      E_DIV: begin
        dvd_r <= DVD_W'(quot_prod >> RSH);
        acc_r <= POW_ONE;
        bit_r <= 3'd7;
      end
      E_POW: begin
        if (frac[bit_r]) acc_r <= acc_step;
        bit_r <= bit_r - 3'd1;
      end
      E_PHI:   p_r   <= P_W'(acc_r) * P_W'(inv_phi);
      E_SCALE: mp_r  <= MP_W'(p_r) * MP_W'(NUM_BUCKETS);
      E_SHIFT: est_r <= est_calc;
      default: ;
    endcase
  end

  `PCSA_ASSERT(a_start_idle, clk, rst_n, start, state_r == E_IDLE, "start while busy")
  `PCSA_ASSERT_NEXT(a_done_pulse, clk, rst_n, done_r, !done_r, "done held over two cycles")
  `PCSA_ASSERT(a_acc_range, clk, rst_n, state_r == E_POW, acc_r < ACC_LIMIT, "pow acc overflow")

endmodule

// ===== bench/tb_pcsa_cardinality_sketch.sv =====
// ---------------------------------------------------------------------------
// PCSA cardinality sketch testbench
// Drives inserts and queries with random gaps and result stalls, mirrors the
// bucket bitmaps and the fixed-point estimator, and checks every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pcsa_cardinality_sketch import pcsa_pkg::*; ;

  localparam int STALL_LIMIT     = 5000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int HOLD_OFF_AT     = 300;
  localparam int RANDOM_ITEMS    = 290;
  localparam int FILL_LEVELS     = 2;
  localparam int SETTLE_CYCLES   = 40;
  localparam logic [INV_PHI_W-1:0] INV_PHI_AT_RESET = 18'd84725;
  localparam logic [INV_PHI_W-1:0] INV_PHI_MAX      = 18'h3FFFF;

  class sketch_mirror;
    logic [63:0] bitmaps [NUM_BUCKETS_DEF];
    logic [63:0] roots [8];
    logic [INV_PHI_W-1:0] inv_phi;
    out_item_t owed_results [$];
    int errors;

    function new();
      foreach (bitmaps[i]) bitmaps[i] = '0;
      roots = '{64'd65714, 64'd65892, 64'd66250, 64'd66971,
                64'd68438, 64'd71468, 64'd77936, 64'd92682};
      inv_phi = INV_PHI_AT_RESET;
      errors = 0;
    endfunction

    function int lowest_zero(logic [63:0] v);
      int n;
      n = 0;
      while (n < 64 && v[n]) n++;
      return n;
    endfunction

    function logic [63:0] pow2_frac(logic [7:0] f);
      logic [63:0] acc;
      acc = 64'd65536;
      for (int j = 7; j >= 0; j--)
        if (f[j]) acc = (acc * roots[j] + 64'd32768) >> 16;
      return acc;
    endfunction

    function logic [63:0] estimate_for(int total);
      int q;
      int r;
      int s;
      logic [7:0] f;
      logic [63:0] phi;
      logic [63:0] buckets;
      logic [63:0] mp;
      q = total / NUM_BUCKETS_DEF;
      r = total % NUM_BUCKETS_DEF;
      f = 8'((r * 256) / NUM_BUCKETS_DEF);
      phi = '0;
      phi[INV_PHI_W-1:0] = inv_phi;
      buckets = 64'(NUM_BUCKETS_DEF);
      mp = pow2_frac(f) * phi * buckets;
      if (mp == 0) return '0;
      if (q < 32) return mp >> (32 - q);
      s = q - 32;
      if (s == 0) return mp;
      if (s >= 64 || (mp >> (64 - s)) != 0) return '1;
      return mp << s;
    endfunction

    function void note_item(in_item_t it);
      out_item_t want;
      logic [63:0] h;
      int idx;
      int total;
      h = it.hash_value;
      want = '0;
      if (it.req_type == REQ_INSERT) begin
        idx = int'((h >> BUCKET_SHIFT_DEF) % NUM_BUCKETS_DEF);
        bitmaps[idx] |= ~h & (h + 64'd1);
      end else begin
        total = 0;
        foreach (bitmaps[i]) total += lowest_zero(bitmaps[i]);
        want.estimate = estimate_for(total);
        want.rank_sum = total[RANK_SUM_W-1:0];
      end
      owed_results.push_back(want);
    endfunction

    function int pending();
      return owed_results.size();
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      if (errors < 100)
        $display("mismatch on %s at %0t: got %0h, want %0h", what, $time, got, want);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      logic [63:0] got_rank;
      logic [63:0] want_rank;
      if (owed_results.size() == 0) begin
        report("result with no item outstanding", got.estimate, '0);
        return;
      end
      want = owed_results.pop_front();
      got_rank = '0;
      want_rank = '0;
      got_rank[RANK_SUM_W-1:0] = got.rank_sum;
      want_rank[RANK_SUM_W-1:0] = want.rank_sum;
      if (got.estimate !== want.estimate) report("estimate", got.estimate, want.estimate);
      if (got.rank_sum !== want.rank_sum) report("rank_sum", got_rank, want_rank);
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_wr_en = 1'b0;
  logic [INV_PHI_W-1:0] cfg_wr_data = '0;

  bit quiet_phase = 1'b0;
  sketch_mirror mirror = new();

  pcsa_cardinality_sketch #(
    .NUM_BUCKETS (NUM_BUCKETS_DEF),
    .BUCKET_SHIFT(BUCKET_SHIFT_DEF)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // hash whose lowest zero sits at rank; below rank 56 the top byte picks the bucket
  function automatic logic [63:0] shaped_hash(int bucket, int rank);
    logic [63:0] h;
    h = rand64();
    h[63:56] = bucket[7:0];
    if (rank >= 64) begin
      h = '1;
    end else begin
      h = h | ((64'd1 << rank) - 64'd1);
      h[rank] = 1'b0;
    end
    return h;
  endfunction

  task automatic offer(input logic req, input logic [63:0] hash);
    int gap;
    in_item_t item;
    gap = quiet_phase ? 0 : $urandom_range(7);
    item.req_type = req;
    item.hash_value = hash;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    mirror.note_item(item);
  endtask

  task automatic write_inv_phi(input logic [INV_PHI_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mirror.inv_phi = value;
  endtask

  initial begin : result_sink
    int stall;
    int taken;
    taken = 0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(7);
      // long hold-off so the block backs up into its input
      if (taken == HOLD_OFF_AT) stall = HOLD_OFF_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      mirror.check_result(out_data);
      taken++;
    end
  end

  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled_cycles = 0;
      else stalled_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int pick;
    int off;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // empty sketch at the reset value of inv_phi
    offer(REQ_QUERY, rand64());
    offer(REQ_INSERT, 64'h0);
    offer(REQ_INSERT, 64'h1);
    offer(REQ_INSERT, 64'h3);
    offer(REQ_INSERT, '1);
    offer(REQ_INSERT, 64'h7FFF_FFFF_FFFF_FFFF);
    offer(REQ_INSERT, 64'hFF00_0000_0000_0000);
    offer(REQ_INSERT, 64'hFF00_0000_0000_0001);
    offer(REQ_INSERT, 64'h00FF_FFFF_FFFF_FFFF);
    offer(REQ_INSERT, 64'hFEFF_FFFF_FFFF_FFFF);
    offer(REQ_QUERY, '1);
    write_inv_phi('0);
    offer(REQ_QUERY, 64'h0);
    write_inv_phi(18'd1);
    offer(REQ_QUERY, rand64());
    write_inv_phi(INV_PHI_MAX);
    offer(REQ_QUERY, rand64());
    write_inv_phi(INV_PHI_AT_RESET);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 100 || n == 200) write_inv_phi(INV_PHI_W'($urandom_range(INV_PHI_MAX, 1)));
      quiet_phase = (n >= 150 && n < 220);
      pick = $urandom_range(99);
      if (pick < 10) offer(REQ_QUERY, rand64());
      else if (pick < 50) offer(REQ_INSERT, rand64());
      else if (pick < 95) offer(REQ_INSERT, shaped_hash($urandom_range(255), $urandom_range(63)));
      else offer(REQ_INSERT, shaped_hash(0, 64));
    end

    // raise every bucket one rank per level
    for (int lvl = 0; lvl < FILL_LEVELS; lvl++) begin
      quiet_phase = lvl[0];
      off = $urandom_range(255);
      for (int b = 0; b < NUM_BUCKETS_DEF; b++)
        offer(REQ_INSERT, shaped_hash((b + off) % NUM_BUCKETS_DEF, lvl));
      offer(REQ_QUERY, rand64());
      if (lvl % 2 == 0) write_inv_phi(INV_PHI_W'($urandom_range(INV_PHI_MAX, 1)));
    end
    quiet_phase = 1'b0;
    for (int k = 56; k < 64; k++)
      repeat (4) offer(REQ_INSERT, shaped_hash($urandom_range(255), k));
    offer(REQ_QUERY, rand64());
    write_inv_phi(INV_PHI_MAX);
    offer(REQ_QUERY, rand64());
    write_inv_phi(18'd1);
    offer(REQ_QUERY, rand64());
    write_inv_phi(INV_PHI_AT_RESET);
    offer(REQ_QUERY, rand64());
    in_valid <= 1'b0;

    while (mirror.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
